// ===== src/bfrm_pkg.sv =====
// Shared constants, state codes and controller/datapath bundles for the running-mean queue.
`timescale 1ns / 1ps

package bfrm_pkg;

  localparam int unsigned MAX_DEPTH_DEF = 8;

  localparam int unsigned WIN_W     = 4;
  localparam int unsigned TAG_W     = 16;
  localparam int unsigned VAL_W     = 9;
  localparam int unsigned CNT_OUT_W = 4;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 4'd5;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_CHK,
    S_INS_DROP,
    S_APPEND,
    S_DIV_GO,
    S_DIV_WAIT,
    S_RM_CHK,
    S_RM_POP,
    S_FINISH
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic drop;
    logic capture;
    logic append;
    logic div_start;
    logic set_err;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_remove;
    logic need_evict;
    logic empty;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

// ===== src/bfrm_in_if.sv =====
// Request channel: valid/ready handshake with the insert/remove word.
`timescale 1ns / 1ps

interface bfrm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [bfrm_pkg::TAG_W-1:0]  entry_tag;
  logic [bfrm_pkg::VAL_W-1:0]  height;

  modport source (output valid, output req_type, output entry_tag, output height,
                  input ready);
  modport sink   (input valid, input req_type, input entry_tag, input height,
                  output ready);
endinterface

// ===== src/bfrm_out_if.sv =====
// Result channel: valid/ready handshake with the status and result word.
`timescale 1ns / 1ps

interface bfrm_out_if;
  logic                            valid;
  logic                            ready;
  logic                            status;
  logic [bfrm_pkg::VAL_W-1:0]      mean_height;
  logic [bfrm_pkg::TAG_W-1:0]      removed_tag;
  logic [bfrm_pkg::VAL_W-1:0]      removed_height;
  logic [bfrm_pkg::CNT_OUT_W-1:0]  queue_count;

  modport source (output valid, output status, output mean_height, output removed_tag,
                  output removed_height, output queue_count, input ready);
  modport sink   (input valid, input status, input mean_height, input removed_tag,
                  input removed_height, input queue_count, output ready);
endinterface

// ===== src/bfrm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bfrm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/bfrm_div.sv =====
// Restoring divider, one quotient bit per cycle, for a quotient known to fit QUO_W bits.
`timescale 1ns / 1ps

module bfrm_div #(
  parameter int unsigned NUM_W = 14,
  parameter int unsigned DEN_W = 5,
  parameter int unsigned QUO_W = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [QUO_W-1:0] quo_o
);

  localparam int unsigned REM_W  = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;
  localparam int unsigned STEP_W = $clog2(QUO_W + 1);

  logic [REM_W-1:0]  rem_q, rem_d;
  logic [REM_W-1:0]  dsh_q, dsh_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              fits;

  assign fits = (rem_q >= dsh_q);

  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = REM_W'(num_i);
      dsh_d  = REM_W'(den_i) << (QUO_W - 1);
      quo_d  = '0;
      step_d = STEP_W'(QUO_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = rem_q - dsh_q;
      end
      quo_d  = {quo_q[QUO_W-2:0], fits};
      dsh_d  = dsh_q >> 1;
      step_d = step_q - STEP_W'(1);
      // last quotient bit lands now
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

endmodule

// ===== src/bfrm_ctrl.sv =====
// Sequencer for insert, evict, remove and result hand-off.
`timescale 1ns / 1ps

module bfrm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  bfrm_pkg::stat_t stat_i,
  output logic            in_ready_o,
  output bfrm_pkg::cmd_t  cmd_o
);

  bfrm_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bfrm_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = stat_i.req_remove ? bfrm_pkg::S_RM_CHK : bfrm_pkg::S_INS_CHK;
        end
      end
      bfrm_pkg::S_INS_CHK: begin
        state_d = stat_i.need_evict ? bfrm_pkg::S_INS_DROP : bfrm_pkg::S_APPEND;
      end
      bfrm_pkg::S_INS_DROP: state_d = bfrm_pkg::S_INS_CHK;
      bfrm_pkg::S_APPEND:   state_d = bfrm_pkg::S_DIV_GO;
      bfrm_pkg::S_DIV_GO:   state_d = bfrm_pkg::S_DIV_WAIT;
      bfrm_pkg::S_DIV_WAIT: begin
        if (stat_i.div_done) begin
          state_d = bfrm_pkg::S_FINISH;
        end
      end
      bfrm_pkg::S_RM_CHK: begin
        state_d = stat_i.empty ? bfrm_pkg::S_FINISH : bfrm_pkg::S_RM_POP;
      end
      bfrm_pkg::S_RM_POP: state_d = bfrm_pkg::S_FINISH;
      bfrm_pkg::S_FINISH: begin
        if (stat_i.out_free) begin
          state_d = bfrm_pkg::S_IDLE;
        end
      end
      default: state_d = bfrm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      bfrm_pkg::S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      bfrm_pkg::S_INS_DROP: cmd_o.drop      = 1'b1;
      bfrm_pkg::S_APPEND:   cmd_o.append    = 1'b1;
      bfrm_pkg::S_DIV_GO:   cmd_o.div_start = 1'b1;
      bfrm_pkg::S_RM_CHK:   cmd_o.set_err   = stat_i.empty;
      bfrm_pkg::S_RM_POP: begin
        cmd_o.drop    = 1'b1;
        cmd_o.capture = 1'b1;
      end
      bfrm_pkg::S_FINISH:   cmd_o.load_out  = stat_i.out_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfrm_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_load_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> state_q == bfrm_pkg::S_IDLE)
    else $error("result loaded without returning to idle");

endmodule

// ===== src/bfrm_dp.sv =====
// Datapath: window register, queue pointers, running sum, entry RAM, divider, result register.
`timescale 1ns / 1ps

module bfrm_dp #(
  parameter int unsigned MAX_DEPTH = bfrm_pkg::MAX_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bfrm_pkg::WIN_W-1:0]       cfg_wdata_i,
  input  logic                             req_type_i,
  input  logic [bfrm_pkg::TAG_W-1:0]       entry_tag_i,
  input  logic [bfrm_pkg::VAL_W-1:0]       height_i,
  input  bfrm_pkg::cmd_t                   cmd_i,
  output bfrm_pkg::stat_t                  stat_o,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic                             status_o,
  output logic [bfrm_pkg::VAL_W-1:0]       mean_height_o,
  output logic [bfrm_pkg::TAG_W-1:0]       removed_tag_o,
  output logic [bfrm_pkg::VAL_W-1:0]       removed_height_o,
  output logic [bfrm_pkg::CNT_OUT_W-1:0]   queue_count_o
);

  localparam int unsigned TAG_W = bfrm_pkg::TAG_W;
  localparam int unsigned VAL_W = bfrm_pkg::VAL_W;
  localparam int unsigned WIN_W = bfrm_pkg::WIN_W;
  localparam int unsigned IDX_W = $clog2(MAX_DEPTH);
  localparam int unsigned PTR_W = IDX_W + 1;
  localparam int unsigned CNT_W = $clog2(MAX_DEPTH + 1);
  localparam int unsigned CAP_W = (CNT_W > WIN_W) ? CNT_W : WIN_W;
  localparam int unsigned SUM_W = VAL_W + CNT_W;
  localparam int unsigned NUM_W = SUM_W + 2;
  localparam int unsigned DEN_W = CNT_W + 1;
  localparam int unsigned ENT_W = TAG_W + VAL_W;

  logic [WIN_W-1:0] window_q, window_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [SUM_W-1:0] sum_q, sum_d;

  logic [TAG_W-1:0] in_tag_q;
  logic [VAL_W-1:0] in_val_q;

  logic             res_status_q;
  logic [VAL_W-1:0] res_mean_q;
  logic [TAG_W-1:0] res_tag_q;
  logic [VAL_W-1:0] res_val_q;

  logic                 out_valid_q, out_valid_d;
  logic                 out_status_q;
  logic [VAL_W-1:0]     out_mean_q;
  logic [TAG_W-1:0]     out_tag_q;
  logic [VAL_W-1:0]     out_val_q;
  logic [bfrm_pkg::CNT_OUT_W-1:0] out_count_q;

  logic [ENT_W-1:0] rd_entry;
  logic [VAL_W-1:0] rd_val;
  logic [TAG_W-1:0] rd_tag;
  logic [PTR_W-1:0] tail_sum;
  logic [IDX_W-1:0] tail_idx;
  logic [IDX_W-1:0] head_inc;
  logic [CAP_W-1:0] win_ext;
  logic [CAP_W-1:0] cap;
  logic             need_evict;
  logic             div_done;
  logic [VAL_W-1:0] div_quo;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;

  assign rd_val = rd_entry[VAL_W-1:0];
  assign rd_tag = rd_entry[ENT_W-1:VAL_W];

  // tail = (head + count) mod depth, the sum stays below twice the depth
  assign tail_sum = PTR_W'(head_q) + PTR_W'(count_q);
  assign tail_idx = (tail_sum >= PTR_W'(MAX_DEPTH)) ? IDX_W'(tail_sum - PTR_W'(MAX_DEPTH))
                                                   : IDX_W'(tail_sum);
  assign head_inc = (head_q == IDX_W'(MAX_DEPTH - 1)) ? '0 : head_q + IDX_W'(1);

  // clamp the window to 1..MAX_DEPTH
  assign win_ext = CAP_W'(window_q);
  always_comb begin
    priority if (win_ext == '0) begin
      cap = CAP_W'(1);
    end else if (win_ext > CAP_W'(MAX_DEPTH)) begin
      cap = CAP_W'(MAX_DEPTH);
    end else begin
      cap = win_ext;
    end
  end

  assign need_evict = (CAP_W'(count_q) >= cap);

  assign div_num = NUM_W'({sum_q, 1'b0}) + NUM_W'(count_q);
  assign div_den = DEN_W'({count_q, 1'b0});

  always_comb begin
    window_d = cfg_we_i ? cfg_wdata_i : window_q;
    head_d   = head_q;
    count_d  = count_q;
    sum_d    = sum_q;
    if (cmd_i.drop) begin
      head_d  = head_inc;
      count_d = count_q - CNT_W'(1);
      sum_d   = sum_q - SUM_W'(rd_val);
    end else if (cmd_i.append) begin
      count_d = count_q + CNT_W'(1);
      sum_d   = sum_q + SUM_W'(in_val_q);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= bfrm_pkg::WINDOW_RESET;
      head_q      <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      window_q    <= window_d;
      head_q      <= head_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      in_tag_q     <= entry_tag_i;
      in_val_q     <= height_i;
      res_status_q <= bfrm_pkg::STATUS_OK;
      res_mean_q   <= '0;
      res_tag_q    <= '0;
      res_val_q    <= '0;
    end
    if (cmd_i.set_err) begin
      res_status_q <= bfrm_pkg::STATUS_EMPTY;
    end
    if (cmd_i.capture) begin
      res_tag_q <= rd_tag;
      res_val_q <= rd_val;
    end
    if (div_done) begin
      res_mean_q <= div_quo;
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_mean_q   <= res_mean_q;
      out_tag_q    <= res_tag_q;
      out_val_q    <= res_val_q;
      out_count_q  <= bfrm_pkg::CNT_OUT_W'(count_q);
    end
  end

  bfrm_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.append),
    .waddr_i (tail_idx),
    .wdata_i ({in_tag_q, in_val_q}),
    .raddr_i (head_q),
    .rdata_o (rd_entry)
  );

  bfrm_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .QUO_W (VAL_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign stat_o.req_remove = (req_type_i == bfrm_pkg::REQ_REMOVE);
  assign stat_o.need_evict = need_evict;
  assign stat_o.empty      = (count_q == '0);
  assign stat_o.div_done   = div_done;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign mean_height_o    = out_mean_q;
  assign removed_tag_o    = out_tag_q;
  assign removed_height_o = out_val_q;
  assign queue_count_o    = out_count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_DEPTH))
    else $error("entry count above depth");

  a_append_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append |-> !need_evict)
    else $error("append into a full window");

  a_drop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.drop |-> count_q != '0 ##1 count_q == $past(count_q) - CNT_W'(1))
    else $error("drop from empty queue or count not decremented");

endmodule

// ===== src/bounded_fifo_running_mean_top.sv =====
// Top level of the bounded queue with running rounded mean.
//
//   port         dir   handshake            word
//   in_i         in    valid/ready          req_type, entry_tag, height
//   out_o        out   valid/ready          status, mean_height, removed_tag,
//                                           removed_height, queue_count
//   cfg_*_i      in    write enable only    window_size (4 bits)
//
// One word at a time. Remove: empty check, then a pop to the result register
// (no pop on an empty queue). Insert: evictions while full, each a RAM read then
// a sum update; append; the bit-serial divider for the mean; the result register.
// Reset clears pointers, count, sum and sets window_size to 5; the entry RAM
// is not cleared. A stalled result holds in the output register while the
// next word is accepted and worked on; it waits only at hand-off.
`timescale 1ns / 1ps

module bounded_fifo_running_mean_top #(
  parameter int unsigned MAX_DEPTH = bfrm_pkg::MAX_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bfrm_pkg::WIN_W-1:0]  cfg_wdata_i,
  bfrm_in_if.sink                     in_i,
  bfrm_out_if.source                  out_o
);

  bfrm_pkg::cmd_t  cmd;
  bfrm_pkg::stat_t stat;

  bfrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .stat_i     (stat),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd)
  );

  bfrm_dp #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .req_type_i       (in_i.req_type),
    .entry_tag_i      (in_i.entry_tag),
    .height_i         (in_i.height),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .status_o         (out_o.status),
    .mean_height_o    (out_o.mean_height),
    .removed_tag_o    (out_o.removed_tag),
    .removed_height_o (out_o.removed_height),
    .queue_count_o    (out_o.queue_count)
  );

endmodule
